// ===== rtl/mtes_pkg.sv =====
// Shared types, codes and helpers for the MIDI track event scanner.
package mtes_pkg;

  // Record kinds
  typedef enum logic [2:0] {
    KIND_CHAN  = 3'd0,
    KIND_TEMPO = 3'd1,
    KIND_SYSEX = 3'd2,
    KIND_META  = 3'd3,
    KIND_END   = 3'd4,
    KIND_ERR   = 3'd5
  } kind_e;

  // Byte codes of the file format
  localparam logic [7:0] META_TEMPO  = 8'h51;
  localparam logic [7:0] META_EOT    = 8'h2F;
  localparam logic [7:0] META_LYRIC  = 8'h05;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_SYSEX_CT = 8'hF7;
  localparam logic [7:0] ST_META     = 8'hFF;
  localparam logic [7:0] DATA_MASK   = 8'h7F;

  // Depth of the queue between parser and output stage
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    kind_e       kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [23:0] tempo;
  } rec_t;

  typedef struct packed {
    logic [15:0] channels_used;
    logic [4:0]  channel_count;
    logic [15:0] track_meta_count;
    logic        lyric_seen;
    logic [31:0] song_ticks;
    logic [1:0]  sysex_spread;
  } stats_t;

  // One queue entry: the records caused by one byte
  typedef struct packed {
    rec_t [1:0] recs;
    logic       two;
    stats_t     stats;
  } entry_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== rtl/mtes_if.sv =====
// Channel interfaces: track bytes in, event records out, configuration write.
interface mtes_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_track;
  logic       last_of_track;
  logic       first_of_song;
  modport source (output valid, data_byte, first_of_track, last_of_track, first_of_song,
                  input ready);
  modport sink   (input valid, data_byte, first_of_track, last_of_track, first_of_song,
                  output ready);
endinterface

interface mtes_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_tick;
  logic [7:0]  status_value;
  logic [23:0] tempo_value;
  logic [15:0] channels_used;
  logic [4:0]  channel_count;
  logic [15:0] track_meta_count;
  logic        lyric_seen;
  logic [31:0] song_ticks;
  logic [1:0]  sysex_spread;
  logic        last_result;
  modport source (output valid, event_kind, event_tick, status_value, tempo_value,
                  channels_used, channel_count, track_meta_count, lyric_seen,
                  song_ticks, sysex_spread, last_result, input ready);
  modport sink   (input valid, event_kind, event_tick, status_value, tempo_value,
                  channels_used, channel_count, track_meta_count, lyric_seen,
                  song_ticks, sysex_spread, last_result, output ready);
endinterface

interface mtes_cfg_if;
  logic valid;
  logic ready;
  logic format_two_mode;
  modport source (output valid, format_two_mode, input ready);
  modport sink   (input valid, format_two_mode, output ready);
endinterface

// ===== rtl/mtes_front.sv =====
// Byte parser: decodes one track byte per cycle while the queue is not full and builds its records.
module mtes_front #(
  parameter int unsigned MAX_TRACKS = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mtes_byte_if.sink          byte_i,
  mtes_cfg_if.sink           cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output mtes_pkg::entry_t   entry_o
);

  localparam int unsigned TRK_W = $clog2(MAX_TRACKS + 1);
  localparam logic [TRK_W-1:0] TRK_MAX = TRK_W'(MAX_TRACKS);

  localparam logic [2:0] PH_DELTA     = 3'd0;
  localparam logic [2:0] PH_STATUS    = 3'd1;
  localparam logic [2:0] PH_META_TYPE = 3'd2;
  localparam logic [2:0] PH_META_LEN1 = 3'd3;
  localparam logic [2:0] PH_META_LENN = 3'd4;
  localparam logic [2:0] PH_TEMPO     = 3'd5;
  localparam logic [2:0] PH_SYSEX_LEN = 3'd6;
  localparam logic [2:0] PH_SKIP      = 3'd7;

  logic             fmt_q;
  logic [2:0]       phase_q, phase_d;
  logic [7:0]       rs_q, rs_d;
  logic [27:0]      dacc_q, dacc_d;
  logic [2:0]       dcnt_q, dcnt_d;
  logic [31:0]      tick_q, tick_d;
  logic [31:0]      let_q, let_d;
  logic [27:0]      skip_q, skip_d;
  logic [27:0]      lacc_q, lacc_d;
  logic [7:0]       ety_q, ety_d;
  logic [23:0]      tacc_q, tacc_d;
  logic [15:0]      mask_q, mask_d;
  logic [4:0]       total_q, total_d;
  logic [15:0]      meta_q, meta_d;
  logic             lyric_q, lyric_d;
  logic [31:0]      song_q, song_d;
  logic [31:0]      off_q, off_d;
  logic [TRK_W-1:0] trk_q, trk_d;
  logic [TRK_W-1:0] sxtrk_q, sxtrk_d;
  logic [1:0]       spread_q, spread_d;
  logic             done_q, done_d;

  mtes_pkg::rec_t [1:0] recs;
  logic [1:0]           nrec;

  logic accept;
  assign byte_i.ready = !full_i;
  assign cfg_i.ready  = 1'b1;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    logic [7:0]  b;
    logic [7:0]  st;
    logic        run;
    logic [1:0]  rem;
    logic [15:0] bit_v;
    logic        fin;
    b        = byte_i.data_byte;
    st       = b;
    run      = 1'b0;
    rem      = 2'd2;
    bit_v    = '0;
    fin      = 1'b0;
    nrec     = 2'd0;
    recs     = '0;
    phase_d  = phase_q;  rs_d   = rs_q;   dacc_d  = dacc_q;  dcnt_d  = dcnt_q;
    tick_d   = tick_q;   let_d  = let_q;  skip_d  = skip_q;  lacc_d  = lacc_q;
    ety_d    = ety_q;    tacc_d = tacc_q; mask_d  = mask_q;  total_d = total_q;
    meta_d   = meta_q;   lyric_d = lyric_q; song_d = song_q; off_d   = off_q;
    trk_d    = trk_q;    sxtrk_d = sxtrk_q; spread_d = spread_q; done_d = done_q;

    // Clear song-wide state
    if (byte_i.first_of_song) begin
      mask_d = '0; total_d = '0; lyric_d = 1'b0; song_d = '0;
      trk_d = '0; sxtrk_d = '0; spread_d = '0;
    end
    // Restart the track
    if (byte_i.first_of_track) begin
      if (trk_d < TRK_MAX) trk_d = trk_d + 1'b1;
      phase_d = PH_DELTA; rs_d = '0; dacc_d = '0; dcnt_d = '0; tick_d = '0;
      let_d = '0; skip_d = '0; lacc_d = '0; ety_d = '0; tacc_d = '0;
      meta_d = '0; done_d = 1'b0;
      off_d = fmt_q ? song_d : 32'd0;
    end

    if (!done_d) begin
      unique case (phase_d)
        PH_DELTA: begin
          dacc_d = {dacc_d[20:0], b[6:0]};
          dcnt_d = dcnt_d + 3'd1;
          if (!b[7] || dcnt_d >= 3'd4) begin
            if (dcnt_d < 3'd4) tick_d = mtes_pkg::sat_add(tick_d, {4'd0, dacc_d});
            dacc_d  = '0;
            dcnt_d  = '0;
            phase_d = PH_STATUS;
          end
        end
        PH_STATUS: begin
          priority if (b == mtes_pkg::ST_META) begin
            if (fmt_q) let_d = tick_d;
            phase_d = PH_META_TYPE;
          end else if (b == mtes_pkg::ST_SYSEX) begin
            let_d = tick_d;
            recs[nrec[0]] = '{mtes_pkg::KIND_SYSEX, mtes_pkg::sat_add(tick_d, off_d),
                              mtes_pkg::ST_SYSEX, 24'd0};
            nrec = nrec + 2'd1;
            if (spread_d == 2'd0) begin
              spread_d = 2'd1;
              sxtrk_d  = trk_d;
            end else if (spread_d == 2'd1 && sxtrk_d != trk_d) begin
              spread_d = 2'd2;
            end
            lacc_d  = '0;
            phase_d = PH_SYSEX_LEN;
          end else if (b == mtes_pkg::ST_SYSEX_CT) begin
            phase_d = PH_DELTA;
          end else if (b[7:4] == 4'hF || (!b[7] && rs_d == 8'd0)) begin
            // Bad system status, or data with no running status
            recs[nrec[0]] = '{mtes_pkg::KIND_ERR, mtes_pkg::sat_add(tick_d, off_d),
                              b, 24'd0};
            nrec    = nrec + 2'd1;
            done_d  = 1'b1;
            phase_d = PH_DELTA;
          end else begin
            if (!b[7]) begin
              st  = rs_d;
              run = 1'b1;
            end
            if (st[7:4] == 4'h8 || st[7:4] == 4'h9) begin
              bit_v = 16'd1 << st[3:0];
              if ((mask_d & bit_v) == 16'd0) begin
                mask_d  = mask_d | bit_v;
                total_d = total_d + 5'd1;
              end
            end
            rem = (st[7:4] == 4'hC || st[7:4] == 4'hD) ? 2'd1 : 2'd2;
            if (run) rem = rem - 2'd1;
            rs_d  = st;
            let_d = tick_d;
            recs[nrec[0]] = '{mtes_pkg::KIND_CHAN, mtes_pkg::sat_add(tick_d, off_d),
                              st, 24'd0};
            nrec    = nrec + 2'd1;
            skip_d  = {26'd0, rem};
            phase_d = (rem == 2'd0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_META_TYPE: begin
          ety_d   = b;
          phase_d = PH_META_LEN1;
        end
        PH_META_LEN1: begin
          priority if (ety_d == mtes_pkg::META_TEMPO && b == 8'h03) begin
            tacc_d  = '0;
            skip_d  = 28'd3;
            phase_d = PH_TEMPO;
          end else if (ety_d == mtes_pkg::META_EOT && b == 8'h00) begin
            fin = 1'b1;
          end else begin
            if (ety_d < 8'h10 && meta_d != 16'hFFFF) meta_d = meta_d + 16'd1;
            if (ety_d == mtes_pkg::META_LYRIC) lyric_d = 1'b1;
            recs[nrec[0]] = '{mtes_pkg::KIND_META, mtes_pkg::sat_add(tick_d, off_d),
                              ety_d, 24'd0};
            nrec   = nrec + 2'd1;
            lacc_d = {21'd0, b[6:0]};
            if (b[7]) begin
              phase_d = PH_META_LENN;
            end else begin
              skip_d  = lacc_d;
              phase_d = (lacc_d == 28'd0) ? PH_DELTA : PH_SKIP;
            end
          end
        end
        PH_META_LENN, PH_SYSEX_LEN: begin
          lacc_d = {lacc_d[20:0], b[6:0]};
          if (!b[7]) begin
            skip_d  = lacc_d;
            phase_d = (lacc_d == 28'd0) ? PH_DELTA : PH_SKIP;
          end
        end
        PH_TEMPO: begin
          tacc_d = {tacc_d[15:0], b};
          if (skip_d != 28'd0) skip_d = skip_d - 28'd1;
          if (skip_d == 28'd0) begin
            recs[nrec[0]] = '{mtes_pkg::KIND_TEMPO, mtes_pkg::sat_add(tick_d, off_d),
                              mtes_pkg::META_TEMPO, tacc_d};
            nrec    = nrec + 2'd1;
            phase_d = PH_DELTA;
          end
        end
        PH_SKIP: begin
          if (skip_d != 28'd0) skip_d = skip_d - 28'd1;
          if (skip_d == 28'd0) phase_d = PH_DELTA;
        end
        default: phase_d = PH_DELTA;
      endcase
      // End of track, from the end meta event or from the chunk boundary
      if (fin || (byte_i.last_of_track && !done_d)) begin
        recs[nrec[0]] = '{mtes_pkg::KIND_END, let_d, mtes_pkg::META_EOT, 24'd0};
        nrec = nrec + 2'd1;
        if (fmt_q) song_d = mtes_pkg::sat_add(song_d, let_d);
        else if (let_d > song_d) song_d = let_d;
        done_d  = 1'b1;
        phase_d = PH_DELTA;
      end
    end
  end

  // Hand the records of this byte to the queue
  assign push_o                 = accept && (nrec != 2'd0);
  assign entry_o.recs           = recs;
  assign entry_o.two            = nrec[1];
  assign entry_o.stats.channels_used    = mask_d;
  assign entry_o.stats.channel_count    = total_d;
  assign entry_o.stats.track_meta_count = meta_d;
  assign entry_o.stats.lyric_seen       = lyric_d;
  assign entry_o.stats.song_ticks       = song_d;
  assign entry_o.stats.sysex_spread     = spread_d;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 1'b0;
    end else if (cfg_i.valid) begin
      fmt_q <= cfg_i.format_two_mode;
    end
  end

  // Parser state, advanced on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA; rs_q <= '0; dacc_q <= '0; dcnt_q <= '0; tick_q <= '0;
      let_q <= '0; skip_q <= '0; lacc_q <= '0; ety_q <= '0; tacc_q <= '0;
      mask_q <= '0; total_q <= '0; meta_q <= '0; lyric_q <= 1'b0; song_q <= '0;
      off_q <= '0; trk_q <= '0; sxtrk_q <= '0; spread_q <= '0; done_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d; rs_q <= rs_d; dacc_q <= dacc_d; dcnt_q <= dcnt_d;
      tick_q <= tick_d; let_q <= let_d; skip_q <= skip_d; lacc_q <= lacc_d;
      ety_q <= ety_d; tacc_q <= tacc_d; mask_q <= mask_d; total_q <= total_d;
      meta_q <= meta_d; lyric_q <= lyric_d; song_q <= song_d; off_q <= off_d;
      trk_q <= trk_d; sxtrk_q <= sxtrk_d; spread_q <= spread_d; done_q <= done_d;
    end
  end

endmodule

// ===== rtl/mtes_queue.sv =====
// Short queue of per-byte record groups between parser and output stage.
module mtes_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mtes_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mtes_pkg::entry_t head_o
);

  localparam int unsigned CNT_W = $clog2(mtes_pkg::QDEPTH + 1);

  mtes_pkg::entry_t                 mem_q [mtes_pkg::QDEPTH];
  logic [mtes_pkg::QPTR_W-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(mtes_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
  end

  // Store an entry
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue pop while empty");
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CNT_W'(mtes_pkg::QDEPTH)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill count");

endmodule

// ===== rtl/mtes_back.sv =====
// Output stage: sends the one or two records of the head entry in order.
module mtes_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mtes_pkg::entry_t head_i,
  output logic             pop_o,
  mtes_event_if.source     evt_o
);

  logic           sel_q, sel_d;
  logic           last;
  logic           take;
  mtes_pkg::rec_t rec;

  assign rec   = head_i.recs[sel_q];
  assign last  = sel_q || !head_i.two;
  assign take  = evt_o.valid && evt_o.ready;
  assign pop_o = take && last;
  assign sel_d = take ? !last : sel_q;

  assign evt_o.valid            = !empty_i;
  assign evt_o.event_kind       = rec.kind;
  assign evt_o.event_tick       = rec.tick;
  assign evt_o.status_value     = rec.status;
  assign evt_o.tempo_value      = rec.tempo;
  assign evt_o.channels_used    = head_i.stats.channels_used;
  assign evt_o.channel_count    = head_i.stats.channel_count;
  assign evt_o.track_meta_count = head_i.stats.track_meta_count;
  assign evt_o.lyric_seen       = head_i.stats.lyric_seen;
  assign evt_o.song_ticks       = head_i.stats.song_ticks;
  assign evt_o.sysex_spread     = head_i.stats.sysex_spread;
  assign evt_o.last_result      = last;

  // Step through the records of the head entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

// ===== rtl/midi_track_event_scanner_core.sv =====
// Top level of the MIDI track event scanner.
// Takes one track byte per cycle and emits channel, tempo, sysex, meta and
// track-end/error records with song-wide statistics. The parser accepts a byte
// every cycle while its four-entry record queue has room; each byte yields zero,
// one or two records, and the output stage sends one record per cycle while the
// receiver is ready. The records of a byte are registered in the queue first.
// The format-2 register must be written on the configuration channel only while
// the block is idle; this is not enforced. The channel is always ready.
module midi_track_event_scanner_core #(
  parameter int unsigned MAX_TRACKS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mtes_byte_if.sink     byte_i,
  mtes_cfg_if.sink      cfg_i,
  mtes_event_if.source  event_o
);

  logic             push, pop, full, empty;
  mtes_pkg::entry_t entry, head;

  mtes_front #(.MAX_TRACKS(MAX_TRACKS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  mtes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  mtes_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .evt_o   (event_o)
  );

endmodule
